[hw/rtl/csrmv_pkg.sv]
// Package for the compressed-row sparse matrix-vector block.
// Holds item kinds, queue entry types, widths and default depths.
// No dependencies.
package csrmv_pkg;

	// field widths
	localparam int POS_W      = 10;
	localparam int DATA_W     = 32;
	localparam int ACC_W      = 64;
	localparam int POS_EXT_W  = 17;

	// item kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// configuration register index (bit 2 of the byte address)
	localparam logic CFG_IDX_MODE = 1'b0;

	// defaults
	localparam int VEC_DEPTH_DEF = 1024;
	localparam int MID_DEPTH     = 4;
	localparam int OUT_DEPTH     = 4;

	// item handed from front to back
	typedef struct packed {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] coef;
		logic signed [DATA_W-1:0] elem;
		logic signed [DATA_W-1:0] rhs;
		logic                     last;
	} mid_item_t;

	// finished row result
	typedef struct packed {
		logic signed [DATA_W-1:0] row_result;
		logic [POS_W-1:0]         row_number;
		logic                     saturated;
	} result_t;

endpackage

[hw/rtl/csr_matvec_defect.sv]
// Sparse matrix times vector, compressed-row order, product or defect mode.
// Throughput: one input beat per cycle while full is low, including loads and empty rows.
// A row-ending beat passes the store read, the middle queue, the multiply register,
// the accumulate register and the output queue before its result shows.
// Reset clears queues, accumulator, row counter and mode; the vector store
// is not cleared and holds no defined value until written.
module csr_matvec_defect #(
	parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          kind,
	input  logic [csrmv_pkg::POS_W-1:0]         position,
	input  logic signed [csrmv_pkg::DATA_W-1:0] value,
	input  logic signed [csrmv_pkg::DATA_W-1:0] rhs,
	input  logic                                row_end,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [csrmv_pkg::DATA_W-1:0] row_result,
	output logic [csrmv_pkg::POS_W-1:0]         row_number,
	output logic                                saturated,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import csrmv_pkg::*;

	localparam int MCW = $clog2(MID_DEPTH+1);
	localparam int OCW = $clog2(OUT_DEPTH+1);

	logic                      mode_q;
	logic                      mid_push;
	logic                      mid_pop;
	logic                      mid_empty;
	logic [MCW-1:0]            mid_count;
	mid_item_t                 mid_in;
	logic [$bits(mid_item_t)-1:0] mid_raw;
	logic                      out_push;
	logic [OCW-1:0]            out_count;
	result_t                   out_in;
	logic [$bits(result_t)-1:0] out_raw;
	result_t                   out_head;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_MODE) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	// front end
	csrmv_front #(
		.VEC_DEPTH (VEC_DEPTH),
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.rhs       (rhs),
		.row_end   (row_end),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_item  (mid_in)
	);

	// queue between front and back
	csrmv_fifo #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_in),
		.rd_en   (mid_pop),
		.rd_data (mid_raw),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	// back end
	csrmv_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_item_t'(mid_raw)),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_in)
	);

	// result queue
	csrmv_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_in),
		.rd_en   (pop),
		.rd_data (out_raw),
		.empty   (empty),
		.count   (out_count)
	);

	assign out_head   = result_t'(out_raw);
	assign row_result = out_head.row_result;
	assign row_number = out_head.row_number;
	assign saturated  = out_head.saturated;

	// checks
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push && !mid_pop |-> mid_count != MCW'(MID_DEPTH))
		else $error("middle queue overflow");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && !(pop && !empty) |-> out_count != OCW'(OUT_DEPTH))
		else $error("result queue overflow");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && saturated |->
		(row_result == 32'sh7fffffff || row_result == 32'sh80000000))
		else $error("saturated result not at a limit");

endmodule

[hw/rtl/csrmv_fifo.sv]
// Small synchronous queue with first-word fall-through and an occupancy count.
// Generic; no package dependency. DEPTH must be a power of two, at least 2.
module csrmv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_rd;

	assign do_rd   = rd_en && (count_q != '0);
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rd_data = store_q[rptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + PW'(1);
			if (do_rd) rptr_q <= rptr_q + PW'(1);
			if (wr_en && !do_rd) count_q <= count_q + CW'(1);
			else if (!wr_en && do_rd) count_q <= count_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) store_q[wptr_q] <= wr_data;
	end

endmodule

[hw/rtl/csrmv_front.sv]
// Front end: accepts input beats, drops unknown kinds, owns the vector store
// and fetches the element for each matrix entry. Uses csrmv_pkg.
module csrmv_front #(
	parameter int VEC_DEPTH = csrmv_pkg::VEC_DEPTH_DEF,
	parameter int MID_DEPTH = csrmv_pkg::MID_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          kind,
	input  logic [csrmv_pkg::POS_W-1:0]         position,
	input  logic signed [csrmv_pkg::DATA_W-1:0] value,
	input  logic signed [csrmv_pkg::DATA_W-1:0] rhs,
	input  logic                                row_end,
	input  logic [$clog2(MID_DEPTH+1)-1:0]      mid_count,
	output logic                                mid_push,
	output csrmv_pkg::mid_item_t                mid_item
);
	import csrmv_pkg::*;

	localparam int AW = $clog2(VEC_DEPTH);
	localparam int CW = $clog2(MID_DEPTH+1);

	logic [DATA_W-1:0]        vec_mem [VEC_DEPTH];
	logic [POS_EXT_W-1:0]     pos_ext;
	logic [AW-1:0]            addr;
	logic                     in_range;
	logic                     accept;
	logic                     keep;

	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic signed [DATA_W-1:0] coef_s1;
	logic signed [DATA_W-1:0] rhs_s1;
	logic                     last_s1;
	logic                     inr_s1;
	logic [DATA_W-1:0]        rd_q;

	// address decode and range check
	assign pos_ext  = POS_EXT_W'(position);
	assign addr     = pos_ext[AW-1:0];
	assign in_range = pos_ext < POS_EXT_W'(VEC_DEPTH);

	// hold off while the queue cannot take this beat and the one in flight
	assign full   = ({1'b0, mid_count} + (CW+1)'(valid_s1)) >= (CW+1)'(MID_DEPTH);
	assign accept = push && !full;
	assign keep   = (kind == KIND_LOAD) || (kind == KIND_ENTRY) || (kind == KIND_EMPTY);

	// vector store: load writes, matrix entry reads
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_LOAD && in_range) vec_mem[addr] <= value;
		if (accept && kind == KIND_ENTRY) rd_q <= vec_mem[addr];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && keep;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= kind;
			coef_s1 <= value;
			rhs_s1  <= rhs;
			last_s1 <= row_end;
			inr_s1  <= in_range;
		end
	end

	// out-of-range columns read as zero
	assign mid_push      = valid_s1;
	assign mid_item.op   = op_s1;
	assign mid_item.coef = coef_s1;
	assign mid_item.elem = inr_s1 ? $signed(rd_q) : '0;
	assign mid_item.rhs  = rhs_s1;
	assign mid_item.last = last_s1;

endmodule

[hw/rtl/csrmv_back.sv]
// Back end: multiply, saturating accumulate, row finish (defect, scale, clamp).
// Pops the middle queue and pushes results to the output queue. Uses csrmv_pkg.
module csrmv_back #(
	parameter int OUT_DEPTH = csrmv_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mode,
	input  logic                           mid_empty,
	input  csrmv_pkg::mid_item_t           mid_item,
	output logic                           mid_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           out_push,
	output csrmv_pkg::result_t             out_item
);
	import csrmv_pkg::*;

	localparam int CW = $clog2(OUT_DEPTH+1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic signed [ACC_W-1:0]  prod_s1;
	logic signed [DATA_W-1:0] rhs_s1;
	logic                     last_s1;

	logic signed [ACC_W-1:0]  acc_q;
	logic [POS_W-1:0]         row_q;
	logic                     emit;

	logic                     valid_s2;
	logic signed [ACC_W-1:0]  sum_s2;
	logic signed [DATA_W-1:0] rhs_s2;
	logic [POS_W-1:0]         row_s2;

	logic [ACC_W:0]           add_w;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  rhs_ext;
	logic [ACC_W:0]           sub_w;
	logic signed [ACC_W-1:0]  defect;
	logic signed [ACC_W-1:0]  qval;
	logic [ACC_W-17:0]        shr;
	logic                     ovf;

	// credit: room in the output queue for everything in flight
	assign mid_pop = !mid_empty &&
		(({1'b0, out_count} + (CW+1)'(valid_s1) + (CW+1)'(valid_s2)) < (CW+1)'(OUT_DEPTH));

	// stage 1: multiply
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			op_s1   <= mid_item.op;
			prod_s1 <= mid_item.coef * mid_item.elem;
			rhs_s1  <= mid_item.rhs;
			last_s1 <= mid_item.last;
		end
	end

	// saturating accumulate
	assign add_w   = {acc_q[ACC_W-1], acc_q} + {prod_s1[ACC_W-1], prod_s1};
	assign acc_sum = (add_w[ACC_W] != add_w[ACC_W-1]) ?
		(add_w[ACC_W] ? ACC_MIN : ACC_MAX) : $signed(add_w[ACC_W-1:0]);

	assign emit = valid_s1 && ((op_s1 == KIND_ENTRY && last_s1) || op_s1 == KIND_EMPTY);

	// stage 2 control: accumulator and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			row_q    <= '0;
		end else begin
			valid_s1 <= mid_pop;
			valid_s2 <= emit;
			if (valid_s1) begin
				case (op_s1)
					KIND_LOAD: begin
						acc_q <= '0;
						row_q <= '0;
					end
					KIND_ENTRY: begin
						acc_q <= last_s1 ? '0 : acc_sum;
						if (last_s1) row_q <= row_q + POS_W'(1);
					end
					KIND_EMPTY: begin
						acc_q <= '0;
						row_q <= row_q + POS_W'(1);
					end
					default: begin
						acc_q <= acc_q;
					end
				endcase
			end
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (emit) begin
			sum_s2 <= (op_s1 == KIND_ENTRY) ? acc_sum : '0;
			rhs_s2 <= rhs_s1;
			row_s2 <= row_q;
		end
	end

	// row finish: optional defect, floor shift by 16, clamp to 32 bits
	assign rhs_ext = {{16{rhs_s2[DATA_W-1]}}, rhs_s2, 16'h0000};
	assign sub_w   = {rhs_ext[ACC_W-1], rhs_ext} - {sum_s2[ACC_W-1], sum_s2};
	assign defect  = (sub_w[ACC_W] != sub_w[ACC_W-1]) ?
		(sub_w[ACC_W] ? ACC_MIN : ACC_MAX) : $signed(sub_w[ACC_W-1:0]);
	assign qval    = mode ? defect : sum_s2;
	assign shr     = qval[ACC_W-1:16];
	assign ovf     = !((&shr[ACC_W-17:DATA_W-1]) || !(|shr[ACC_W-17:DATA_W-1]));

	assign out_push            = valid_s2;
	assign out_item.row_result = ovf ? (shr[ACC_W-17] ? RES_MIN : RES_MAX)
		: $signed(shr[DATA_W-1:0]);
	assign out_item.row_number = row_s2;
	assign out_item.saturated  = ovf;

endmodule

[tb/csr_matvec_defect_tb.sv]
// Self-checking testbench for csr_matvec_defect, the sparse row-times-vector block.
// Depends on csrmv_pkg for item kinds, the register index and the result type.
// Scoreboard: a predictor works out every row result, and the monitor checks each popped beat.
`timescale 1ns / 100ps

module csr_matvec_defect_tb;
	import csrmv_pkg::*;

	localparam logic [1:0] KIND_NONE   = 2'd3;   // reserved kind, ignored by the block
	localparam int         STALL_LIMIT = 2000;
	localparam int         SETTLE_CYC  = 8;
	localparam longint     ACC_MAX     = 64'h7fff_ffff_ffff_ffff;
	localparam longint     ACC_MIN     = 64'h8000_0000_0000_0000;
	localparam longint     Q_MAX       = 64'sh7fff_ffff;
	localparam longint     Q_MIN       = -64'sh8000_0000;
	localparam logic [31:0] W_MAX      = 32'h7fff_ffff;
	localparam logic [31:0] W_MIN      = 32'h8000_0000;
	localparam logic [31:0] W_ONE      = 32'h0001_0000;
	localparam logic [31:0] W_NEG      = 32'hffff_ffff;

	typedef struct {
		logic [1:0]        kind;
		logic [POS_W-1:0]  pos;
		logic signed [31:0] val;
		logic signed [31:0] rhs;
		logic              last;
	} beat_t;

	// block ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         kind = '0;
	logic [POS_W-1:0]   position = '0;
	logic signed [31:0] value = '0;
	logic signed [31:0] rhs = '0;
	logic               row_end = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [31:0] row_result;
	logic [POS_W-1:0]   row_number;
	logic               saturated;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// stimulus and scoreboard
	beat_t   pend_q[$];
	beat_t   next_beat;
	beat_t   in_beat;
	result_t exp_rows[$];
	int      errors = 0;
	int      gen_count = 0;
	int      cyc = 0;
	int      stall_cnt = 0;
	int      col_pool[$];
	bit      col_seen[1024];

	// predictor state
	logic signed [31:0] vec_mem[1024];
	longint             acc = 0;
	logic [POS_W-1:0]   row_cnt = '0;
	logic               mode_q = 1'b0;

	csr_matvec_defect u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.rhs       (rhs),
		.row_end   (row_end),
		.empty     (empty),
		.pop       (pop),
		.row_result(row_result),
		.row_number(row_number),
		.saturated (saturated),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// random idle in the early part of each repeating window, and none in the rest of it
	function automatic bit take_break();
		return (cyc % 1500) < 1100 && $urandom_range(0, 99) < 9;
	endfunction

	// clip a 65-bit sum back to the signed 64-bit range
	function automatic longint clip64(input logic [64:0] w);
		if (w[64] != w[63])
			return w[64] ? ACC_MIN : ACC_MAX;
		return w[63:0];
	endfunction

	// close the current row: product sum or rhs minus sum, Q32.32 to Q16.16
	task automatic emit_row(input logic signed [31:0] row_rhs);
		longint         q;
		longint         r;
		logic [64:0]    wide;
		result_t        res;
		q = acc;
		if (mode_q) begin
			r    = longint'(row_rhs) <<< 16;
			wide = {r[63], r} - {q[63], q};
			q    = clip64(wide);
		end
		r = q >>> 16;
		res.saturated = 1'b0;
		if (r > Q_MAX) begin
			r = Q_MAX;
			res.saturated = 1'b1;
		end
		if (r < Q_MIN) begin
			r = Q_MIN;
			res.saturated = 1'b1;
		end
		res.row_result = r[31:0];
		res.row_number = row_cnt;
		exp_rows.push_back(res);
		acc     = 0;
		row_cnt = row_cnt + 1'b1;
	endtask

	// update the model state with one accepted input beat
	task automatic predict_beat(input beat_t b);
		longint      prod;
		logic [64:0] wide;
		case (b.kind)
			KIND_LOAD: begin
				vec_mem[b.pos] = b.val;
				acc     = 0;
				row_cnt = '0;
			end
			KIND_ENTRY: begin
				prod = longint'(b.val) * longint'(vec_mem[b.pos]);
				wide = {acc[63], acc} + {prod[63], prod};
				acc  = clip64(wide);
				if (b.last)
					emit_row(b.rhs);
			end
			KIND_EMPTY: begin
				acc = 0;
				emit_row(b.rhs);
			end
			default: ;
		endcase
	endtask

	// compare a popped beat with the oldest expected row
	task automatic check_row();
		result_t want;
		if (exp_rows.size() == 0) begin
			$display("%0t: unexpected row beat, expected none, got result %0d row %0d sat %0b",
				$time, row_result, row_number, saturated);
			errors++;
		end else begin
			want = exp_rows.pop_front();
			if (row_result !== want.row_result) begin
				$display("%0t: row_result expected %0d, got %0d", $time,
					$signed(want.row_result), row_result);
				errors++;
			end
			if (row_number !== want.row_number) begin
				$display("%0t: row_number expected %0d, got %0d", $time,
					want.row_number, row_number);
				errors++;
			end
			if (saturated !== want.saturated) begin
				$display("%0t: saturated expected %0b, got %0b (row %0d)", $time,
					want.saturated, saturated, want.row_number);
				errors++;
			end
		end
	endtask

	// input driver: a held beat stays put until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (pend_q.size() != 0 && !take_break()) begin
				next_beat = pend_q.pop_front();
				push     <= 1'b1;
				kind     <= next_beat.kind;
				position <= next_beat.pos;
				value    <= next_beat.val;
				rhs      <= next_beat.rhs;
				row_end  <= next_beat.last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= !take_break();
	end

	// monitor: check the output beat, then predict from the input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_row();
			if (push && !full) begin
				in_beat.kind = kind;
				in_beat.pos  = position;
				in_beat.val  = value;
				in_beat.rhs  = rhs;
				in_beat.last = row_end;
				predict_beat(in_beat);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || psel) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	task automatic add_beat(input logic [1:0] k, input logic [POS_W-1:0] p,
			input logic [31:0] v, input logic [31:0] r, input logic e);
		beat_t b;
		b.kind = k;
		b.pos  = p;
		b.val  = v;
		b.rhs  = r;
		b.last = e;
		pend_q.push_back(b);
		if (k != KIND_NONE)
			gen_count++;
	endtask

	// Q16.16 value leaning towards extremes, zero and small magnitudes
	function automatic logic [31:0] rand_q16();
		case ($urandom_range(0, 7))
			0: return W_MAX;
			1: return W_MIN;
			2: return '0;
			3, 4: return $urandom_range(0, 32'h3ffff) - 32'h2_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic gen_load(input int p);
		add_beat(KIND_LOAD, POS_W'(p), rand_q16(), $urandom, 1'($urandom_range(0, 1)));
		if (!col_seen[p]) begin
			col_seen[p] = 1'b1;
			col_pool.push_back(p);
		end
	endtask

	// one row over loaded columns; length 0 gives an empty-row beat
	task automatic gen_row(input int len, input bit allow_breaks);
		int col;
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 99) < 3)
				add_beat(KIND_NONE, POS_W'($urandom), $urandom, $urandom,
					1'($urandom_range(0, 1)));
			if (allow_breaks && $urandom_range(0, 99) < 2)
				gen_load($urandom_range(0, 1023));
			col = col_pool[$urandom_range(0, col_pool.size() - 1)];
			add_beat(KIND_ENTRY, POS_W'(col), rand_q16(), $urandom, n == len - 1);
		end
		if (len == 0)
			add_beat(KIND_EMPTY, POS_W'($urandom), rand_q16(), $urandom,
				1'($urandom_range(0, 1)));
	endtask

	function automatic int short_row_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			return 0;
		if (pick < 70)
			return 1;
		return $urandom_range(2, 4);
	endfunction

	// drain everything in flight, then let the pipeline settle
	task automatic wait_idle();
		while (pend_q.size() != 0 || push || exp_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write the mode register, then read it back
	task automatic set_mode(input logic m);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {CFG_IDX_MODE, 2'b00};
		pwdata  <= {31'b0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		mode_q   = m;
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {31'b0, m}) begin
			$display("%0t: mode readback expected %0h, got %0h", $time, {31'b0, m}, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// product mode: extremes, saturation both ways, rounding, empty row, mid-row load
		set_mode(1'b0);
		gen_load(0);
		pend_q[$].val = W_MAX;
		gen_load(1023);
		pend_q[$].val = W_MIN;
		gen_load(5);
		pend_q[$].val = W_ONE;
		gen_load(6);
		pend_q[$].val = W_NEG;
		add_beat(KIND_ENTRY, 1023, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 1023, W_MIN, $urandom, 1'b1);
		add_beat(KIND_ENTRY, 5, W_ONE, $urandom, 1'b1);
		add_beat(KIND_ENTRY, 6, W_NEG, $urandom, 1'b1);
		add_beat(KIND_ENTRY, 5, W_NEG, $urandom, 1'b1);
		add_beat(KIND_EMPTY, 0, 0, W_MAX, 1'b0);
		add_beat(KIND_NONE, '1, '1, '1, 1'b1);
		add_beat(KIND_ENTRY, 0, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 0, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 0, W_MIN, $urandom, 1'b1);
		add_beat(KIND_ENTRY, 0, 1, $urandom, 1'b0);
		add_beat(KIND_LOAD, 1023, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 5, 0, $urandom, 1'b1);

		// defect mode: exact rhs, clipping of rhs minus sum at both ends
		wait_idle();
		set_mode(1'b1);
		add_beat(KIND_ENTRY, 5, 0, W_MAX, 1'b1);
		add_beat(KIND_ENTRY, 1023, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 1023, W_MIN, W_MIN, 1'b1);
		add_beat(KIND_ENTRY, 0, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 0, W_MIN, $urandom, 1'b0);
		add_beat(KIND_ENTRY, 0, W_MIN, W_MAX, 1'b1);
		add_beat(KIND_EMPTY, '1, W_MAX, W_MIN, 1'b1);

		// random rows with vector reloads and broken rows
		wait_idle();
		set_mode(1'b0);
		gen_count = 0;
		while (gen_count < 160) begin
			repeat ($urandom_range(1, 8)) gen_load($urandom_range(0, 1023));
			repeat ($urandom_range(3, 12)) gen_row($urandom_range(0, 6), 1'b1);
		end

		// long run of short rows without reloads, so the row number wraps
		for (int ph = 0; ph < 2; ph++) begin
			wait_idle();
			set_mode(ph == 0);
			repeat (550) gen_row(short_row_len(), 1'b0);
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (errors == 0 && exp_rows.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
